[hdl/fpfa_pkg.sv]
package fpfa_pkg;

	localparam int PARTITIONS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 1'd1;

	localparam logic FIT_FIRST = 1'b0;
	localparam logic FIT_BEST  = 1'b1;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic [1:0] STATUS_LOADED  = 2'd0;
	localparam logic [1:0] STATUS_GRANTED = 2'd1;
	localparam logic [1:0] STATUS_WAITING = 2'd2;

	localparam logic [4:0] PART_COUNT_RST = 5'd16;

	typedef struct packed {
		logic        operation;
		logic [3:0]  slot_index;
		logic [15:0] block_size;
		logic        new_run;
	} fpfa_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  granted_index;
		logic [15:0] granted_size;
	} fpfa_rsp_t;

endpackage

[hdl/fixed_partition_fit_allocator_unit.sv]
// Channel   Valid      Stall      Payload
// cfg       cfg_we     -          cfg_index, cfg_data
// req       req_valid  req_stall  req_data (fpfa_req_t)
// rsp       rsp_valid  rsp_stall  rsp_data (fpfa_rsp_t)
//
// A load goes from acceptance straight to the done state and the output register; a
// request first scans n = min(partition_count, PARTITIONS) entries, as one comparator
// walks the size memory one entry a cycle through its registered read port.
// Reset clears the taken marks and the control and configuration registers; sizes are unset until loaded.
// req_stall is high from acceptance until the result enters the output
// register, which holds it while rsp_stall is high.
module fixed_partition_fit_allocator_unit
	import fpfa_pkg::*;
#(
	parameter int PARTITIONS = PARTITIONS_DEF,
	parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  fpfa_req_t             req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output fpfa_rsp_t             rsp_data
);

	localparam int IDX_W = $clog2(PARTITIONS);
	localparam int CNT_W = $clog2(PARTITIONS + 1);
	localparam int CMP_W = (SIZE_BITS > 16) ? SIZE_BITS : 16;
	localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]           state_q;
	logic                 fit_mode_q;
	logic [4:0]           part_count_q;
	logic [PARTITIONS-1:0] taken_q;

	logic [SIZE_BITS-1:0] mem [PARTITIONS];
	logic [SIZE_BITS-1:0] rd_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 vld_s1;

	logic                 op_q;
	logic [15:0]          size_q;
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     scan_q;
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] best_q;

	logic                 out_vld_q;
	fpfa_rsp_t            out_q;

	logic                 req_acc;
	logic                 out_free;
	logic                 load_hit;
	logic [CNT_W-1:0]     n_use;
	logic                 fits;
	logic                 better;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !out_vld_q || !rsp_stall;
	assign load_hit  = req_acc && (req_data.operation == OP_LOAD)
		&& (32'(req_data.slot_index) < PARTITIONS);

	always_comb begin
		if (LIM_W'(part_count_q) > LIM_W'(PARTITIONS)) begin
			n_use = CNT_W'(PARTITIONS);
		end else begin
			n_use = CNT_W'(part_count_q);
		end
	end

	assign fits   = !taken_q[idx_s1] && (CMP_W'(rd_s1) >= CMP_W'(size_q));
	assign better = !found_q || ((fit_mode_q == FIT_BEST) && (rd_s1 < best_q));

	// size memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (load_hit) begin
			mem[IDX_W'(req_data.slot_index)] <= SIZE_BITS'(req_data.block_size);
		end
		rd_s1  <= mem[scan_q[IDX_W-1:0]];
		idx_s1 <= scan_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q   <= FIT_FIRST;
			part_count_q <= PART_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIT_MODE:   fit_mode_q   <= cfg_data[0];
				REG_PART_COUNT: part_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			taken_q   <= '0;
			vld_s1    <= 1'b0;
			found_q   <= 1'b0;
			out_vld_q <= 1'b0;
			scan_q    <= '0;
		end else begin
			if (out_vld_q && !rsp_stall && (state_q != ST_DONE)) begin
				out_vld_q <= 1'b0;
			end
			if (vld_s1 && fits && better) begin
				found_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						found_q <= 1'b0;
						scan_q  <= '0;
						if (req_data.operation == OP_LOAD) begin
							if (load_hit) begin
								taken_q[IDX_W'(req_data.slot_index)] <= 1'b0;
							end
							state_q <= ST_DONE;
						end else begin
							if (req_data.new_run) begin
								taken_q <= '0;
							end
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_q < n_q) begin
						vld_s1 <= 1'b1;
						scan_q <= scan_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						if (op_q == OP_ALLOC && found_q) begin
							taken_q[pick_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q   <= req_data.operation;
			size_q <= req_data.block_size;
			n_q    <= n_use;
		end
		if (vld_s1 && fits && better) begin
			pick_q <= idx_s1;
			best_q <= rd_s1;
		end
		if (state_q == ST_DONE && out_free) begin
			if (op_q == OP_LOAD) begin
				out_q.status        <= STATUS_LOADED;
				out_q.granted_index <= '0;
				out_q.granted_size  <= '0;
			end else if (found_q) begin
				out_q.status        <= STATUS_GRANTED;
				out_q.granted_index <= 4'(pick_q);
				out_q.granted_size  <= 16'(best_q);
			end else begin
				out_q.status        <= STATUS_WAITING;
				out_q.granted_index <= '0;
				out_q.granted_size  <= '0;
			end
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp_data  = out_q;

endmodule
